>>> rtl/cwt_pkg.sv
// Shared types and codes for the card ID whitelist table.
package cwt_pkg;

	localparam int ID_W   = 32;
	localparam int SLOT_W = 8;

	localparam logic [ID_W-1:0] EMPTY_ID = '1;

	typedef enum logic [1:0] {
		OP_CHECK      = 2'd0,
		OP_REGISTER   = 2'd1,
		OP_UNREGISTER = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_INVALID  = 4'd0,
		ST_GRANTED  = 4'd1,
		ST_DENIED   = 4'd2,
		ST_ALREADY  = 4'd3,
		ST_STORED   = 4'd4,
		ST_FULL     = 4'd5,
		ST_REMOVED  = 4'd6,
		ST_NOT_REG  = 4'd7,
		ST_CLEARED  = 4'd8
	} status_t;

	// Response payload handed from the controller to the output register.
	typedef struct packed {
		logic [3:0]        status;
		logic [SLOT_W-1:0] slot;
	} cwt_rsp_t;

	// Single-port memory access: one read or one write per cycle.
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [SLOT_W-1:0] addr;
		logic [ID_W-1:0]   wdata;
	} cwt_mem_req_t;

endpackage

>>> rtl/cwt_ram.sv
// Single-port ID storage with registered read data.
module cwt_ram import cwt_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  cwt_mem_req_t      req,
	output logic [ID_W-1:0]   rd_data
);

	logic [ID_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr[AW-1:0]] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data <= mem_q[req.addr[AW-1:0]];
		end
	end

endmodule

>>> rtl/cwt_ctrl.sv
// Request sequencer: table walk, per-entry valid bits, update and result.
module cwt_ctrl import cwt_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [ID_W-1:0]   card_id,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cwt_rsp_t          rsp,
	output cwt_mem_req_t      mem_req,
	input  logic [ID_W-1:0]   mem_rd_data
);

	localparam logic [SLOT_W-1:0] NONE_SLOT = SLOT_W'(DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_FIN,
		S_RESP
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [ID_W-1:0]   key_q;
	logic [SLOT_W-1:0] cnt_q;
	logic              rd_s1;
	logic [AW-1:0]     addr_s1;
	logic              hit_found_q;
	logic [SLOT_W-1:0] hit_idx_q;
	logic              free_found_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic [DEPTH-1:0]  valid_q;
	cwt_rsp_t          rsp_q;

	logic ent_valid;
	logic ent_match;
	logic ent_free;

	// An entry without its valid bit reads as empty.
	assign ent_valid = valid_q[addr_s1];
	assign ent_match = rd_s1 && ent_valid && (mem_rd_data == key_q);
	assign ent_free  = rd_s1 && !ent_valid;

	assign in_ready  = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign rsp       = rsp_q;

	always_comb begin
		mem_req.rd_en = (state_q == S_SCAN);
		mem_req.wr_en = (state_q == S_FIN) && (op_q == OP_REGISTER)
			&& !hit_found_q && free_found_q;
		mem_req.wdata = key_q;
		if (state_q == S_FIN) begin
			mem_req.addr = free_idx_q;
		end else begin
			mem_req.addr = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_CHECK;
			key_q        <= '0;
			cnt_q        <= '0;
			rd_s1        <= 1'b0;
			addr_s1      <= '0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			valid_q      <= '0;
			rsp_q        <= '0;
		end else begin
			rd_s1   <= (state_q == S_SCAN);
			addr_s1 <= cnt_q[AW-1:0];

			// keep the lowest matching and the lowest empty index
			if (ent_match && !hit_found_q) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= SLOT_W'(addr_s1);
			end
			if (ent_free && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= SLOT_W'(addr_s1);
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= op_t'(op);
						key_q        <= card_id;
						cnt_q        <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						if (op_t'(op) == OP_CLEAR) begin
							valid_q      <= '0;
							rsp_q.status <= ST_CLEARED;
							rsp_q.slot   <= NONE_SLOT;
							state_q      <= S_RESP;
						end else if (card_id == EMPTY_ID) begin
							rsp_q.status <= ST_INVALID;
							rsp_q.slot   <= NONE_SLOT;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_SLOT) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					case (op_q)
						OP_CHECK: begin
							if (hit_found_q) begin
								rsp_q.status <= ST_GRANTED;
								rsp_q.slot   <= hit_idx_q;
							end else begin
								rsp_q.status <= ST_DENIED;
								rsp_q.slot   <= NONE_SLOT;
							end
						end
						OP_REGISTER: begin
							if (hit_found_q) begin
								rsp_q.status <= ST_ALREADY;
								rsp_q.slot   <= hit_idx_q;
							end else if (free_found_q) begin
								valid_q[free_idx_q[AW-1:0]] <= 1'b1;
								rsp_q.status <= ST_STORED;
								rsp_q.slot   <= free_idx_q;
							end else begin
								rsp_q.status <= ST_FULL;
								rsp_q.slot   <= NONE_SLOT;
							end
						end
						OP_UNREGISTER: begin
							if (hit_found_q) begin
								valid_q[hit_idx_q[AW-1:0]] <= 1'b0;
								rsp_q.status <= ST_REMOVED;
								rsp_q.slot   <= hit_idx_q;
							end else begin
								rsp_q.status <= ST_NOT_REG;
								rsp_q.slot   <= NONE_SLOT;
							end
						end
						default: begin
							rsp_q.status <= ST_CLEARED;
							rsp_q.slot   <= NONE_SLOT;
						end
					endcase
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/card_id_whitelist_table.sv
// Top level of the card ID whitelist table: sequencer, ID memory, output register.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+-----------
//  request | in_valid, in_ready, op, card_id      | in
//  result  | out_valid, out_ready, status, slot   | out
//
// A check, register or unregister request with a usable ID walks the whole ID
// memory, one entry a cycle through its single port, then passes S_WAIT and
// S_FIN before its result reaches the output register; the sequencer is
// ready for the next request in the cycle after. Clear-all and an all-ones ID
// skip the walk and go straight to S_RESP, and the sequencer is again ready in
// the cycle after the result reaches the output register. Per-entry valid
// bits live in flops and reset or clear-all wipes them at once, so there is no
// clearing pass; an entry without its valid bit reads as empty. The output
// register frees the sequencer while a result waits; a stalled result blocks
// the sequencer only once a second result is ready. Table updates happen at
// the end of the walk, one request at a time, so walks and writes never touch
// the memory in the same cycle.
module card_id_whitelist_table import cwt_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [ID_W-1:0]   card_id,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [3:0]        status,
	output logic [SLOT_W-1:0] slot
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	cwt_mem_req_t    mem_req;
	logic [ID_W-1:0] mem_rd_data;
	logic            rsp_valid;
	logic            rsp_ready;
	cwt_rsp_t        rsp;

	logic            out_valid_q;
	cwt_rsp_t        out_q;

	cwt_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.card_id     (card_id),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data)
	);

	cwt_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	// output register takes a new result whenever it is empty or being drained
	assign rsp_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (rsp_ready) begin
				out_valid_q <= rsp_valid;
				if (rsp_valid) begin
					out_q <= rsp;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_q.status;
	assign slot      = out_q.slot;

endmodule

>>> tb/card_id_whitelist_table_tb.sv
// Self-checking testbench for the card ID whitelist table: random and directed requests.
`timescale 1ns / 1ps

module card_id_whitelist_table_tb;
	import cwt_pkg::*;

	localparam int TABLE_DEPTH = 128;
	localparam int POOL_SIZE   = 200;   // more IDs than entries, so fill bursts hit full
	localparam int N_RANDOM    = 850;
	localparam int HOLD_OFF    = 1000;  // long result stall, well past the two-deep buffering
	localparam int LIMIT       = 1000000;

	// Scoreboard: shadow copy of the ID table plus the queue of predicted results.
	class card_table_scoreboard;
		typedef struct {
			op_t               op;
			logic [ID_W-1:0]   id;
			status_t           status;
			logic [SLOT_W-1:0] slot;
		} expected_rsp_t;

		logic [ID_W-1:0] card_ids [TABLE_DEPTH];
		expected_rsp_t   expected_q [$];
		int              mismatches;

		function new();
			foreach (card_ids[k])
				card_ids[k] = EMPTY_ID;
			mismatches = 0;
		endfunction

		// Lowest entry holding key, TABLE_DEPTH on a miss.
		function int find_slot(logic [ID_W-1:0] key);
			for (int k = 0; k < TABLE_DEPTH; k++)
				if (card_ids[k] == key)
					return k;
			return TABLE_DEPTH;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Predict the result of one accepted request and update the shadow table.
		function void note_request(op_t o, logic [ID_W-1:0] id);
			expected_rsp_t e;
			int            hit;
			e.op   = o;
			e.id   = id;
			e.slot = SLOT_W'(TABLE_DEPTH);
			if (o == OP_CLEAR) begin
				foreach (card_ids[k])
					card_ids[k] = EMPTY_ID;
				e.status = ST_CLEARED;
			end else if (id == EMPTY_ID) begin
				e.status = ST_INVALID;
			end else begin
				hit = find_slot(id);
				case (o)
					OP_CHECK: begin
						if (hit < TABLE_DEPTH) begin
							e.status = ST_GRANTED;
							e.slot   = SLOT_W'(hit);
						end else begin
							e.status = ST_DENIED;
						end
					end
					OP_REGISTER: begin
						if (hit < TABLE_DEPTH) begin
							e.status = ST_ALREADY;
							e.slot   = SLOT_W'(hit);
						end else begin
							hit = find_slot(EMPTY_ID);
							if (hit < TABLE_DEPTH) begin
								card_ids[hit] = id;
								e.status      = ST_STORED;
								e.slot        = SLOT_W'(hit);
							end else begin
								e.status = ST_FULL;
							end
						end
					end
					default: begin
						if (hit < TABLE_DEPTH) begin
							card_ids[hit] = EMPTY_ID;
							e.status      = ST_REMOVED;
							e.slot        = SLOT_W'(hit);
						end else begin
							e.status = ST_NOT_REG;
						end
					end
				endcase
			end
			expected_q.push_back(e);
		endfunction

		function void check_result(logic [3:0] st, logic [SLOT_W-1:0] sl);
			expected_rsp_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result status=%0d slot=%0d", $time, st, sl);
				return;
			end
			e = expected_q.pop_front();
			if (st !== e.status || sl !== e.slot) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: %s id=%h: expected status=%0d slot=%0d, got status=%0d slot=%0d",
						$time, e.op.name(), e.id, e.status, e.slot, st, sl);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        op;
	logic [ID_W-1:0]   card_id;
	logic              out_valid;
	logic              out_ready;
	logic [3:0]        status;
	logic [SLOT_W-1:0] slot;

	card_table_scoreboard sb;
	logic [ID_W-1:0]      id_pool [POOL_SIZE];
	int                   sent;
	int                   cycle_count = 0;
	bit                   long_stall_go;

	card_id_whitelist_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.card_id  (card_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.slot     (slot)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: a correct run finishes far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Monitor: check the result first, then log the request, so a result and a
	// request on the same edge never pair up with each other.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(status, slot);
			if (in_valid && in_ready)
				sb.note_request(op_t'(op), card_id);
		end
	end

	// Offer one request; valid stays up on return so a back-to-back request
	// does not drop it.
	task automatic send_req(input op_t o, input logic [ID_W-1:0] id);
		in_valid <= 1'b1;
		op       <= o;
		card_id  <= id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// Sender gap: mostly none, some short, a few long.
	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 55)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(15, 60);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop sending until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Mixed traffic, mostly on pool IDs so hits are common.
	task automatic send_mixed(input int n, input bit with_gaps);
		int              r;
		op_t             o;
		logic [ID_W-1:0] id;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				o = OP_CHECK;
			else if (r < 65)
				o = OP_REGISTER;
			else if (r < 97)
				o = OP_UNREGISTER;
			else
				o = OP_CLEAR;
			r = $urandom_range(0, 99);
			if (r < 85)
				id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			else if (r < 95)
				id = $urandom;
			else
				id = EMPTY_ID;
			send_req(o, id);
			if (with_gaps)
				idle_gap();
		end
	endtask

	// Result side: random ready pattern, plus one long hold-off on request.
	initial begin
		int r;
		int n;
		bit val;
		bit stall_taken;
		stall_taken = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_stall_go && !stall_taken) begin
				stall_taken = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					val = 1'b1;
					n   = $urandom_range(1, 30);
				end else if (r < 85) begin
					val = 1'b0;
					n   = $urandom_range(1, 4);
				end else if (r < 95) begin
					val = 1'b0;
					n   = $urandom_range(10, 40);
				end else begin
					val = 1'b1;
					n   = 100;
				end
				out_ready <= val;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		// Directed: empty table, invalid IDs on every op, extreme IDs, duplicate,
		// remove and reuse of the lowest free entry, clear-all with assorted IDs.
		op_t             dir_op [20];
		logic [ID_W-1:0] dir_id [20];
		int  kind;
		int  base;
		bit  stall_issued;
		bit  drain_issued;

		dir_op = '{
			OP_CHECK, OP_CHECK, OP_REGISTER, OP_UNREGISTER, OP_UNREGISTER,
			OP_REGISTER, OP_REGISTER, OP_REGISTER, OP_REGISTER, OP_CHECK,
			OP_UNREGISTER, OP_UNREGISTER, OP_REGISTER, OP_CHECK, OP_CLEAR,
			OP_CHECK, OP_CLEAR, OP_REGISTER, OP_CHECK, OP_CLEAR
		};
		dir_id = '{
			32'h1234_5678, EMPTY_ID, EMPTY_ID, EMPTY_ID, 32'h1234_5678,
			32'h0000_0000, 32'hFFFF_FFFE, 32'h8000_0001, 32'h0000_0000, 32'hFFFF_FFFE,
			32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, EMPTY_ID,
			32'hFFFF_FFFE, 32'h0000_0000, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'h5A5A_5A5A
		};

		sb            = new();
		sent          = 0;
		long_stall_go = 1'b0;
		stall_issued  = 1'b0;
		drain_issued  = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_CHECK;
		card_id       = '0;

		id_pool[0] = 32'h0000_0000;
		id_pool[1] = 32'hFFFF_FFFE;
		id_pool[2] = 32'h8000_0000;
		id_pool[3] = 32'h0000_0001;
		for (int k = 4; k < POOL_SIZE; k++) begin
			id_pool[k] = $urandom;
			if (id_pool[k] == EMPTY_ID)
				id_pool[k] = 32'h0000_0002;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_op[k]) begin
			send_req(dir_op[k], dir_id[k]);
			idle_gap();
		end
		drain();

		// Random part: fill bursts drive the table to full, mixed bursts
		// exercise hits and misses, single clears empty it now and then.
		sent = 0;
		while (sent < N_RANDOM) begin
			kind = $urandom_range(0, 99);
			if (!stall_issued && sent >= 300) begin
				// Long result stall while requests keep coming: the block
				// fills up and must hold off its request side.
				stall_issued  = 1'b1;
				long_stall_go = 1'b1;
				send_mixed(8, 1'b0);
			end else if (!drain_issued && sent >= 600) begin
				drain_issued = 1'b1;
				drain();
			end else if (sent == 0 || kind < 8) begin
				// Distinct pool IDs, a few more than the table holds.
				base = $urandom_range(0, POOL_SIZE - 1);
				for (int k = 0; k < TABLE_DEPTH + 4; k++) begin
					send_req(OP_REGISTER, id_pool[(base + k) % POOL_SIZE]);
					idle_gap();
				end
			end else if (kind < 11) begin
				send_req(OP_CLEAR, $urandom);
				idle_gap();
			end else begin
				send_mixed($urandom_range(10, 30), 1'b1);
			end
		end

		drain();
		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/cwt_pkg.sv
rtl/cwt_ram.sv
rtl/cwt_ctrl.sv
rtl/card_id_whitelist_table.sv
tb/card_id_whitelist_table_tb.sv
